// File: src/abb_pkg.sv
package abb_pkg;

   // Framebuffer geometry and source image limit.
   localparam int FRAME_WIDTH     = 640;
   localparam int FRAME_HEIGHT    = 480;
   localparam int SOURCE_MAX_SIDE = 256;
   localparam int FB_PIXELS       = FRAME_WIDTH * FRAME_HEIGHT;

   // Field widths.
   localparam int ORIGIN_W = 12;
   localparam int COORD_W  = 8;
   localparam int CHAN_W   = 8;
   localparam int PIXEL_W  = 32;
   localparam int IDX_W    = 19;
   localparam int CSR_W    = 32;
   localparam int PADDR_W  = 3;

   // Signed width that holds origin plus coordinate and every frame limit.
   localparam int POS_W = 14;

   // Full scale of one color channel.
   localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hFF;

   // Register select, taken from the word address bit of paddr.
   localparam logic REG_ORIGIN_X = 1'b0;
   localparam logic REG_ORIGIN_Y = 1'b1;

endpackage

// File: src/abb_over_channel.sv
// One channel of the premultiplied over operator, three register stages:
// operand capture, product, then divide by 255 with saturation.
module abb_over_channel (
   input  logic                       clock,
   input  logic [abb_pkg::CHAN_W-1:0] alpha,
   input  logic [abb_pkg::CHAN_W-1:0] src_chan,
   input  logic [abb_pkg::CHAN_W-1:0] dst_chan,
   output logic [abb_pkg::CHAN_W-1:0] result
);

   localparam int CW = abb_pkg::CHAN_W;
   localparam int PW = 2 * CW;

   logic [CW-1:0] s1_src_ff;
   logic [CW-1:0] s1_dst_ff;
   logic [CW-1:0] s1_inv_ff;
   logic [CW-1:0] s1_inv_in;
   logic [CW-1:0] s2_src_ff;
   logic [PW-1:0] s2_prod_ff;
   logic [PW-1:0] s2_prod_in;
   logic [PW:0]   quot_sum;
   logic [CW-1:0] quot;
   logic [CW:0]   total;
   logic [CW-1:0] s3_res_ff;
   logic [CW-1:0] s3_res_in;

   // Stage one: inverse source alpha.
   assign s1_inv_in = abb_pkg::CHAN_MAX - alpha;

   // Stage two: destination times inverse alpha.
   assign s2_prod_in = PW'(s1_dst_ff) * PW'(s1_inv_ff);

   // Stage three: exact floor division by 255 for any product of two
   // channel values, followed by the add and clamp at full scale.
   assign quot_sum  = (PW+1)'(s2_prod_ff) + (PW+1)'(s2_prod_ff >> CW) + (PW+1)'(1);
   assign quot      = quot_sum[PW-1:CW];
   assign total     = (CW+1)'(s2_src_ff) + (CW+1)'(quot);
   assign s3_res_in = total[CW] ? abb_pkg::CHAN_MAX : total[CW-1:0];

   always_ff @(posedge clock) begin
      s1_src_ff  <= src_chan;
      s1_dst_ff  <= dst_chan;
      s1_inv_ff  <= s1_inv_in;
      s2_src_ff  <= s1_src_ff;
      s2_prod_ff <= s2_prod_in;
      s3_res_ff  <= s3_res_in;
   end

   assign result = s3_res_ff;

endmodule

// File: src/abb_addr.sv
// Position path, three register stages: offset by the origin, clip and
// scale the row, then form the linear framebuffer index.
module abb_addr (
   input  logic                                clock,
   input  logic signed [abb_pkg::ORIGIN_W-1:0] origin_x,
   input  logic signed [abb_pkg::ORIGIN_W-1:0] origin_y,
   input  logic        [abb_pkg::COORD_W-1:0]  src_col,
   input  logic        [abb_pkg::COORD_W-1:0]  src_row,
   output logic                                write_enable,
   output logic        [abb_pkg::IDX_W-1:0]    fb_index
);

   localparam int PW = abb_pkg::POS_W;
   localparam int MW = 2 * PW;

   logic signed [PW-1:0] s1_fx_ff;
   logic signed [PW-1:0] s1_fx_in;
   logic signed [PW-1:0] s1_fy_ff;
   logic signed [PW-1:0] s1_fy_in;
   logic                 s1_src_ok_ff;
   logic                 s1_src_ok_in;
   logic                 s2_inside_ff;
   logic                 s2_inside_in;
   logic [MW-1:0]        s2_row_base_ff;
   logic [MW-1:0]        s2_row_base_in;
   logic [PW-1:0]        s2_fx_ff;
   logic [MW-1:0]        lin_sum;
   logic                 s3_we_ff;
   logic [abb_pkg::IDX_W-1:0] s3_idx_ff;
   logic [abb_pkg::IDX_W-1:0] s3_idx_in;

   // Stage one: frame coordinates and the source size check.
   assign s1_fx_in = PW'(origin_x) + $signed(PW'(src_col));
   assign s1_fy_in = PW'(origin_y) + $signed(PW'(src_row));
   assign s1_src_ok_in = (PW'(src_col) < PW'(abb_pkg::SOURCE_MAX_SIDE)) &&
                         (PW'(src_row) < PW'(abb_pkg::SOURCE_MAX_SIDE));

   // Stage two: clip against the frame and scale the row by the frame width.
   assign s2_inside_in = s1_src_ok_ff &&
                         !s1_fx_ff[PW-1] &&
                         (s1_fx_ff < $signed(PW'(abb_pkg::FRAME_WIDTH))) &&
                         !s1_fy_ff[PW-1] &&
                         (s1_fy_ff < $signed(PW'(abb_pkg::FRAME_HEIGHT)));
   assign s2_row_base_in = MW'(unsigned'(s1_fy_ff)) * MW'(abb_pkg::FRAME_WIDTH);

   // Stage three: add the column; a clipped pixel gets index zero.
   assign lin_sum   = s2_row_base_ff + MW'(s2_fx_ff);
   assign s3_idx_in = s2_inside_ff ? lin_sum[abb_pkg::IDX_W-1:0] : '0;

   always_ff @(posedge clock) begin
      s1_fx_ff       <= s1_fx_in;
      s1_fy_ff       <= s1_fy_in;
      s1_src_ok_ff   <= s1_src_ok_in;
      s2_inside_ff   <= s2_inside_in;
      s2_row_base_ff <= s2_row_base_in;
      s2_fx_ff       <= unsigned'(s1_fx_ff);
      s3_we_ff       <= s2_inside_ff;
      s3_idx_ff      <= s3_idx_in;
   end

   assign write_enable = s3_we_ff;
   assign fb_index     = s3_idx_ff;

endmodule

// File: src/alpha_blend_blit_pixel_unit.sv
// Per-pixel stage of an alpha-blending blitter.
// Input channel: a transaction is taken at each rising edge where start is
// high and busy is low. busy is always low, so a pixel may enter on every
// cycle. Each transaction carries the source pixel (RGBA), its column and
// row in the source image, and the destination pixel (ARGB) from memory.
// Result channel: rsp_strobe is high for exactly one cycle per transaction,
// after its last register stage, with the write enable, the linear
// framebuffer index and the blended ARGB pixel. Results come out in order.
// Throughput is one pixel per clock; results pass through the three register
// stages of the blend path (operands, product, divide and clamp), which the
// position path matches stage for stage.
// The receiver cannot stall; every result must be taken when it is shown.
// Configuration: origin_x at byte address 0 and origin_y at 4, 12 bits
// signed, via APB; user must write them only while no pixel is in flight.
// The block does not enforce this. Reset clears both origins and drops every
// pixel in flight; no pixel that was taken before reset produces a result.
module alpha_blend_blit_pixel_unit (
   input  logic                                clock,
   input  logic                                reset,
   // Input channel.
   input  logic                                start,
   output logic                                busy,
   input  logic [abb_pkg::COORD_W-1:0]         req_src_col,
   input  logic [abb_pkg::COORD_W-1:0]         req_src_row,
   input  logic [abb_pkg::PIXEL_W-1:0]         req_src_rgba,
   input  logic [abb_pkg::PIXEL_W-1:0]         req_dst_pixel,
   // Result channel.
   output logic                                rsp_strobe,
   output logic                                rsp_write_enable,
   output logic [abb_pkg::IDX_W-1:0]           rsp_fb_index,
   output logic [abb_pkg::PIXEL_W-1:0]         rsp_blended_pixel,
   // Configuration port.
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [abb_pkg::PADDR_W-1:0]         paddr,
   input  logic [abb_pkg::CSR_W-1:0]           pwdata,
   output logic [abb_pkg::CSR_W-1:0]           prdata,
   output logic                                pready
);

   localparam int CW = abb_pkg::CHAN_W;
   localparam int OW = abb_pkg::ORIGIN_W;
   localparam int DEPTH = 3;

   logic signed [OW-1:0] csr_origin_x_ff;
   logic signed [OW-1:0] csr_origin_y_ff;
   logic                 csr_write;
   logic                 csr_sel;
   logic [DEPTH-1:0]     valid_ff;
   logic [DEPTH-1:0]     valid_in;
   logic                 accept;
   logic [CW-1:0]        src_a;
   logic [CW-1:0]        blend_a;
   logic [CW-1:0]        blend_r;
   logic [CW-1:0]        blend_g;
   logic [CW-1:0]        blend_b;

   // Configuration registers.
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign csr_sel   = paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_origin_x_ff <= '0;
         csr_origin_y_ff <= '0;
      end else if (csr_write) begin
         case (csr_sel)
            abb_pkg::REG_ORIGIN_X: csr_origin_x_ff <= pwdata[OW-1:0];
            abb_pkg::REG_ORIGIN_Y: csr_origin_y_ff <= pwdata[OW-1:0];
            default: ;
         endcase
      end
   end

   // Read data, sign extended to the bus width.
   always_comb begin
      case (csr_sel)
         abb_pkg::REG_ORIGIN_X: prdata = abb_pkg::CSR_W'(csr_origin_x_ff);
         abb_pkg::REG_ORIGIN_Y: prdata = abb_pkg::CSR_W'(csr_origin_y_ff);
         default:               prdata = '0;
      endcase
   end

   // Valid bits follow the pixels down the pipeline.
   assign busy     = 1'b0;
   assign accept   = start && !busy;
   assign valid_in = {valid_ff[DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign src_a = req_src_rgba[CW-1:0];

   // Blend datapath, one lane per channel.
   abb_over_channel u_chan_a (
      .clock     (clock),
      .alpha     (src_a),
      .src_chan  (src_a),
      .dst_chan  (req_dst_pixel[4*CW-1:3*CW]),
      .result    (blend_a)
   );

   abb_over_channel u_chan_r (
      .clock     (clock),
      .alpha     (src_a),
      .src_chan  (req_src_rgba[4*CW-1:3*CW]),
      .dst_chan  (req_dst_pixel[3*CW-1:2*CW]),
      .result    (blend_r)
   );

   abb_over_channel u_chan_g (
      .clock     (clock),
      .alpha     (src_a),
      .src_chan  (req_src_rgba[3*CW-1:2*CW]),
      .dst_chan  (req_dst_pixel[2*CW-1:CW]),
      .result    (blend_g)
   );

   abb_over_channel u_chan_b (
      .clock     (clock),
      .alpha     (src_a),
      .src_chan  (req_src_rgba[2*CW-1:CW]),
      .dst_chan  (req_dst_pixel[CW-1:0]),
      .result    (blend_b)
   );

   // Position and clipping path.
   abb_addr u_addr (
      .clock        (clock),
      .origin_x     (csr_origin_x_ff),
      .origin_y     (csr_origin_y_ff),
      .src_col      (req_src_col),
      .src_row      (req_src_row),
      .write_enable (rsp_write_enable),
      .fb_index     (rsp_fb_index)
   );

   assign rsp_strobe        = valid_ff[DEPTH-1];
   assign rsp_blended_pixel = {blend_a, blend_r, blend_g, blend_b};

`ifndef ASSERT_OFF
   // Every accepted transaction yields a result after the pipeline depth.
   a_accept_to_result: assert property (
      @(posedge clock) disable iff (reset)
      accept |-> ##3 rsp_strobe
   ) else $error("accepted transaction produced no result");

   // A result only appears for a transaction taken at the pipeline depth before.
   a_result_has_source: assert property (
      @(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, 3)
   ) else $error("result without a matching transaction");

   // A clipped pixel reports index zero.
   a_clip_index_zero: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_write_enable) |-> (rsp_fb_index == '0)
   ) else $error("clipped pixel with nonzero index");

   // A written pixel lands inside the framebuffer.
   a_index_in_frame: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_write_enable) |->
         ((abb_pkg::FB_PIXELS > (1 << abb_pkg::IDX_W)) ||
          (32'(rsp_fb_index) < 32'(abb_pkg::FB_PIXELS)))
   ) else $error("framebuffer index out of range");
`endif

endmodule
